FILE: hw/rtl/gha_pkg.sv
package gha_pkg;

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_GET    = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// Request item
	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  slot_id;
		logic [31:0] generation;
		logic [63:0] entry_data;
	} req_t;

	// Response item
	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  handle_slot;
		logic [31:0] handle_generation;
		logic [63:0] read_data;
		logic [6:0]  live_count;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;   // request transfer this cycle
		logic look;     // pick the slot for an insert
		logic commit;   // apply the update and load the response
	} gha_cmd_t;

endpackage

FILE: hw/rtl/generational_handle_allocator_unit.sv
// Generational handle allocator: a store of SLOTS entry words addressed by
// (slot, generation) handles. Insert takes the most recently freed slot, else
// the next never-used one, and returns the new handle; remove and get succeed
// only for a live slot whose generation matches. One request is in work at a
// time: remove, get and clear go from the request transfer to the execute
// state, insert through a look state first, because the free-stack read and
// then the generation memory read are each registered. The controller is
// back in idle the cycle after the load, so a new request is taken only once
// the last response is loaded. The response sits in an output register, so
// the next request is taken while an earlier response waits to transfer.
// Clear all completes in one pass through the flow (live and generation-valid
// flags are flip-flops), with no sweep of the memories.
module generational_handle_allocator_unit #(
	parameter int SLOTS      = 64,
	parameter int ENTRY_BITS = 64,
	parameter int GEN_BITS   = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gha_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gha_pkg::rsp_t rsp
);
	import gha_pkg::*;

	gha_cmd_t cmd;

	gha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.operation),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	gha_dp #(
		.SLOTS      (SLOTS),
		.ENTRY_BITS (ENTRY_BITS),
		.GEN_BITS   (GEN_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

FILE: hw/rtl/gha_ctrl.sv
module gha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_op,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output gha_pkg::gha_cmd_t cmd
);
	import gha_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   valid_q;

	// Commands from current state
	always_comb begin
		cmd.accept = (state_q == S_IDLE) && req_valid;
		cmd.look   = (state_q == S_LOOK);
		cmd.commit = (state_q == S_EXEC) && (!valid_q || !rsp_stall);
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = valid_q;

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= (req_op == OP_INSERT) ? S_LOOK : S_EXEC;
					end
				end
				S_LOOK: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> valid_q)
		else $error("response not shown after commit");

	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(cmd.commit))
		else $error("response valid without commit");

	a_insert_looks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && req_op == OP_INSERT) |=> cmd.look)
		else $error("insert skipped slot selection");

endmodule

FILE: hw/rtl/gha_dp.sv
module gha_dp #(
	parameter int SLOTS      = 64,
	parameter int ENTRY_BITS = 64,
	parameter int GEN_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gha_pkg::gha_cmd_t cmd,
	input  gha_pkg::req_t     req,
	output gha_pkg::rsp_t     rsp
);
	import gha_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	// Storage
	logic [ENTRY_BITS-1:0] ent_mem [SLOTS];
	logic [GEN_BITS-1:0]   gen_mem [SLOTS];
	logic [SW-1:0]         stk_mem [SLOTS];
	logic [SLOTS-1:0]      live_q;
	logic [SLOTS-1:0]      genv_q;   // generation written since last clear
	logic [CW-1:0]         depth_q;
	logic [CW-1:0]         unused_q;
	logic [CW-1:0]         count_q;

	// Item registers
	logic [1:0]            op_q;
	logic [5:0]            slot_q;
	logic [31:0]           gen_q;
	logic [ENTRY_BITS-1:0] data_q;
	logic [SW-1:0]         id_q;
	logic                  range_q;
	logic                  pop_q;
	logic                  full_q;

	// Read data
	logic [SW-1:0]         stk_rd_q;
	logic [GEN_BITS-1:0]   gen_rd_q;
	logic [ENTRY_BITS-1:0] ent_rd_q;

	rsp_t rsp_q;

	logic [SW-1:0]       look_id;
	logic [SW-1:0]       gen_raddr;
	logic [GEN_BITS-1:0] gen_cur;
	logic [GEN_BITS-1:0] gen_inc;
	logic                hok;
	logic                gen_we;
	logic                ent_we;
	logic                stk_we;
	logic                mark_live;
	logic                mark_dead;
	logic                wipe;
	logic [CW-1:0]       depth_n;
	logic [CW-1:0]       unused_n;
	logic [CW-1:0]       count_n;
	rsp_t                res;

	// Insert slot: top of free stack, else next unused
	assign look_id   = (depth_q != '0) ? stk_rd_q : SW'(unused_q);
	assign gen_raddr = cmd.look ? look_id : SW'(req.slot_id);

	// Handle check
	assign gen_cur = genv_q[id_q] ? gen_rd_q : '0;
	assign gen_inc = gen_cur + GEN_BITS'(1);
	assign hok     = range_q && live_q[id_q] && (32'(gen_cur) == gen_q);

	// Operation decode and result
	always_comb begin
		res       = '0;
		gen_we    = 1'b0;
		ent_we    = 1'b0;
		stk_we    = 1'b0;
		mark_live = 1'b0;
		mark_dead = 1'b0;
		wipe      = 1'b0;
		depth_n   = depth_q;
		unused_n  = unused_q;
		count_n   = count_q;
		res.status = ST_OK;
		case (op_q)
			OP_INSERT: begin
				if (full_q) begin
					res.status = ST_FULL;
				end else begin
					gen_we    = 1'b1;
					ent_we    = 1'b1;
					mark_live = 1'b1;
					if (pop_q) begin
						depth_n = depth_q - CW'(1);
					end else begin
						unused_n = unused_q + CW'(1);
					end
					if (count_q < SLOTS_C) begin
						count_n = count_q + CW'(1);
					end
					res.handle_slot       = 6'(id_q);
					res.handle_generation = 32'(gen_inc);
				end
			end
			OP_REMOVE: begin
				if (hok && (depth_q < SLOTS_C)) begin
					stk_we    = 1'b1;
					gen_we    = 1'b1;
					mark_dead = 1'b1;
					depth_n   = depth_q + CW'(1);
					if (count_q != '0) begin
						count_n = count_q - CW'(1);
					end
				end else begin
					res.status = ST_INVALID;
				end
			end
			OP_GET: begin
				if (hok) begin
					res.read_data = 64'(ent_rd_q);
				end else begin
					res.status = ST_INVALID;
				end
			end
			default: begin
				// clear all
				wipe     = 1'b1;
				depth_n  = '0;
				unused_n = '0;
				count_n  = '0;
			end
		endcase
		res.live_count = 7'(count_n);
	end

	// Slot state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q   <= '0;
			genv_q   <= '0;
			depth_q  <= '0;
			unused_q <= '0;
			count_q  <= '0;
		end else if (cmd.commit) begin
			depth_q  <= depth_n;
			unused_q <= unused_n;
			count_q  <= count_n;
			if (wipe) begin
				live_q <= '0;
				genv_q <= '0;
			end else begin
				if (mark_live) live_q[id_q] <= 1'b1;
				if (mark_dead) live_q[id_q] <= 1'b0;
				if (gen_we)    genv_q[id_q] <= 1'b1;
			end
		end
	end

	// Item capture and slot selection
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= req.operation;
			slot_q  <= req.slot_id;
			gen_q   <= req.generation;
			data_q  <= ENTRY_BITS'(req.entry_data);
			id_q    <= SW'(req.slot_id);
			range_q <= (32'(req.slot_id) < 32'(SLOTS));
		end else if (cmd.look) begin
			id_q   <= look_id;
			pop_q  <= (depth_q != '0);
			full_q <= (depth_q == '0) && (unused_q >= SLOTS_C);
		end
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	// Memories: registered reads, writes on commit
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			stk_rd_q <= stk_mem[SW'(depth_q - CW'(1))];
			ent_rd_q <= ent_mem[SW'(req.slot_id)];
		end
		if (cmd.accept || cmd.look) begin
			gen_rd_q <= gen_mem[gen_raddr];
		end
		if (cmd.commit && gen_we) begin
			gen_mem[id_q] <= gen_inc;
		end
		if (cmd.commit && ent_we) begin
			ent_mem[id_q] <= data_q;
		end
		if (cmd.commit && stk_we) begin
			stk_mem[SW'(depth_q)] <= SW'(slot_q);
		end
	end

	assign rsp = rsp_q;

	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(depth_q + count_q) == unused_q))
		else $error("free and live slots do not add up");

	a_unused_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(unused_q <= SLOTS_C))
		else $error("unused slot pointer past end");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(depth_q <= unused_q))
		else $error("free stack deeper than slots handed out");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import gha_pkg::*;

	localparam int SLOTS       = 64;
	localparam int ENTRY_BITS  = 64;
	localparam int GEN_BITS    = 32;
	localparam int IDLE_LIMIT  = 5000;   // cycles with no transfer on either side
	localparam int TAIL_CYCLES = 20;     // well past the insert latency
	localparam int PRINT_CAP   = 40;

	typedef struct packed {
		logic [5:0]  slot;
		logic [31:0] gen;
	} handle_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	generational_handle_allocator_unit #(
		.SLOTS(SLOTS),
		.ENTRY_BITS(ENTRY_BITS),
		.GEN_BITS(GEN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Allocator shadow state
	logic [31:0] gen_tab [SLOTS];
	logic        live_tab [SLOTS];
	logic [63:0] word_tab [SLOTS];
	logic [5:0]  recycle_stk [SLOTS];
	logic        ever_written [SLOTS];
	int          recycle_top = 0;
	int          untouched_next = 0;
	int          live_now = 0;

	rsp_t    pending_rsp [$];
	handle_t live_handles [$];
	handle_t stale_handles [$];

	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_inserted = 0;
	int n_full = 0;
	int n_rejected = 0;
	int n_reads = 0;
	int n_clears = 0;

	// Sender pacing
	int burst_left = 0;
	int gap_max = 2;

	// Receiver pacing
	logic [15:0] stall_mask = '0;
	int          stall_phase = 0;
	int          hold_left = 0;
	int          hold_request = 0;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			gen_tab[i] = '0;
			live_tab[i] = 1'b0;
			word_tab[i] = '0;
			recycle_stk[i] = '0;
			ever_written[i] = 1'b0;
		end
	end

	function automatic logic handle_live(logic [5:0] s, logic [31:0] g);
		return live_tab[s] && (gen_tab[s] == g);
	endfunction

	// Expected response for one request; advances the shadow state
	function automatic rsp_t predict_op(req_t r);
		rsp_t o;
		int   id;
		logic got;
		o = '0;
		o.status = ST_OK;
		id = 0;
		got = 1'b1;
		case (r.operation)
			OP_INSERT: begin
				if (recycle_top > 0) begin
					recycle_top--;
					id = int'(recycle_stk[recycle_top]);
				end else if (untouched_next < SLOTS) begin
					id = untouched_next;
					untouched_next++;
				end else begin
					got = 1'b0;
				end
				if (got) begin
					gen_tab[id] = gen_tab[id] + 32'd1;
					live_tab[id] = 1'b1;
					word_tab[id] = r.entry_data;
					ever_written[id] = 1'b1;
					live_now++;
					o.handle_slot = id[5:0];
					o.handle_generation = gen_tab[id];
					n_inserted++;
				end else begin
					o.status = ST_FULL;
					n_full++;
				end
			end
			OP_REMOVE: begin
				if (handle_live(r.slot_id, r.generation) && recycle_top < SLOTS) begin
					recycle_stk[recycle_top] = r.slot_id;
					recycle_top++;
					gen_tab[r.slot_id] = gen_tab[r.slot_id] + 32'd1;
					live_tab[r.slot_id] = 1'b0;
					live_now--;
				end else begin
					o.status = ST_INVALID;
					n_rejected++;
				end
			end
			OP_GET: begin
				if (handle_live(r.slot_id, r.generation)) begin
					o.read_data = word_tab[r.slot_id];
					n_reads++;
				end else begin
					o.status = ST_INVALID;
					n_rejected++;
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					gen_tab[i] = '0;
					live_tab[i] = 1'b0;
				end
				recycle_top = 0;
				untouched_next = 0;
				live_now = 0;
				n_clears++;
			end
		endcase
		o.live_count = live_now[6:0];
		return o;
	endfunction

	// Keep the lists of good and stale handles in step with the shadow state
	function automatic void track_handles(req_t r, rsp_t o);
		if (r.operation == OP_INSERT && o.status == ST_OK) begin
			live_handles.push_back({o.handle_slot, o.handle_generation});
		end else if (r.operation == OP_REMOVE && o.status == ST_OK) begin
			for (int i = 0; i < live_handles.size(); i++) begin
				if (live_handles[i].slot == r.slot_id) begin
					stale_handles.push_back(live_handles[i]);
					live_handles.delete(i);
					break;
				end
			end
		end else if (r.operation == OP_CLEAR) begin
			foreach (live_handles[i])
				stale_handles.push_back(live_handles[i]);
			live_handles.delete();
		end
		while (stale_handles.size() > 32)
			void'(stale_handles.pop_front());
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		n_errors++;
		if (n_errors <= PRINT_CAP)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	// One request transfer, then a random gap at the end of a burst
	task automatic send_req(input req_t item);
		rsp_t want;
		int   gap;
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		want = predict_op(item);
		pending_rsp.push_back(want);
		track_handles(item, want);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic issue(input logic [1:0] op, input logic [5:0] s, input logic [31:0] g,
			input logic [63:0] d);
		req_t r;
		r.operation = op;
		r.slot_id = s;
		r.generation = g;
		r.entry_data = d;
		send_req(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() > 0)
			@(posedge clk);
	endtask

	// Mostly well-formed handle traffic, with some stale, corrupted or random handles
	function automatic req_t make_random_req();
		req_t    r;
		handle_t h;
		int      pick;
		int      p_ins;
		r.entry_data = {$urandom, $urandom};
		r.slot_id = 6'($urandom);
		r.generation = $urandom;
		r.operation = OP_INSERT;
		p_ins = (live_handles.size() > 48) ? 20 : 42;
		pick = $urandom_range(0, 99);
		if (pick < p_ins) begin
			r.operation = OP_INSERT;
		end else if (pick < 92 && live_handles.size() > 0) begin
			h = live_handles[$urandom_range(0, live_handles.size() - 1)];
			r.slot_id = h.slot;
			r.generation = h.gen;
			r.operation = (pick < p_ins + (92 - p_ins) / 2) ? OP_REMOVE : OP_GET;
		end else if (pick < 99) begin
			case ($urandom_range(0, 2))
				0: begin
					if (stale_handles.size() > 0) begin
						h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
						r.slot_id = h.slot;
						r.generation = h.gen;
					end
				end
				1: begin
					if (live_handles.size() > 0) begin
						h = live_handles[$urandom_range(0, live_handles.size() - 1)];
						r.slot_id = h.slot;
						r.generation = h.gen ^ (32'd1 << $urandom_range(0, 31));
					end
				end
				default: ;
			endcase
			r.operation = $urandom_range(0, 1) ? OP_REMOVE : OP_GET;
			// never read an entry that has not been written since reset
			if (r.operation == OP_GET && !ever_written[r.slot_id])
				r.operation = OP_REMOVE;
		end else begin
			r.operation = OP_CLEAR;
		end
		return r;
	endfunction

	// Field extremes, stale and double removes, LIFO reuse, clear
	task automatic test_directed();
		issue(OP_REMOVE, 6'd0, 32'd0, '0);
		issue(OP_REMOVE, 6'd63, 32'hFFFF_FFFF, '1);
		issue(OP_INSERT, 6'd63, 32'hFFFF_FFFF, 64'h0);
		issue(OP_INSERT, 6'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		issue(OP_INSERT, 6'd0, 32'd0, 64'hA5A5_5A5A_F00F_0FF0);
		issue(OP_GET, 6'd0, 32'd1, '0);
		issue(OP_GET, 6'd1, 32'd1, '1);
		issue(OP_GET, 6'd1, 32'h8000_0001, '0);
		issue(OP_GET, 6'd1, 32'd0, '0);
		issue(OP_REMOVE, 6'd1, 32'd1, '0);
		issue(OP_REMOVE, 6'd1, 32'd1, '0);
		issue(OP_GET, 6'd1, 32'd1, '0);
		issue(OP_INSERT, 6'd0, 32'd0, 64'h0123_4567_89AB_CDEF);
		issue(OP_GET, 6'd1, 32'd3, '0);
		issue(OP_REMOVE, 6'd0, 32'd1, '0);
		issue(OP_REMOVE, 6'd2, 32'd1, '0);
		issue(OP_INSERT, 6'd0, 32'd0, 64'h1111_2222_3333_4444);
		issue(OP_INSERT, 6'd0, 32'd0, 64'h5555_6666_7777_8888);
		issue(OP_INSERT, 6'd0, 32'd0, 64'h8000_0000_0000_0001);
		issue(OP_GET, 6'd2, 32'd3, '0);
		issue(OP_CLEAR, 6'd63, 32'hFFFF_FFFF, '1);
		issue(OP_GET, 6'd3, 32'd1, '0);
		issue(OP_INSERT, 6'd0, 32'd0, 64'hDEAD_BEEF_0000_FFFF);
		issue(OP_GET, 6'd0, 32'd1, '0);
	endtask

	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_max = 0;
					1: gap_max = 3;
					default: gap_max = 8;
				endcase
			end
			send_req(make_random_req());
		end
	endtask

	// Fill every slot, overflow, empty in random order, refill from the free stack
	task automatic test_store_full();
		handle_t h;
		issue(OP_CLEAR, 6'd0, 32'd0, '0);
		for (int i = 0; i < SLOTS + 3; i++)
			issue(OP_INSERT, 6'($urandom), $urandom, {$urandom, $urandom});
		for (int i = 0; i < 20; i++) begin
			h = live_handles[$urandom_range(0, live_handles.size() - 1)];
			issue(OP_GET, h.slot, h.gen, '0);
		end
		while (live_handles.size() > 0) begin
			h = live_handles[$urandom_range(0, live_handles.size() - 1)];
			issue(OP_REMOVE, h.slot, h.gen, {$urandom, $urandom});
		end
		for (int i = 0; i < SLOTS + 2; i++)
			issue(OP_INSERT, 6'($urandom), $urandom, {$urandom, $urandom});
	endtask

	// Receiver holds off long enough for the request side to back up
	task automatic test_backpressure();
		gap_max = 0;
		hold_request = 300;
		for (int i = 0; i < 60; i++)
			send_req(make_random_req());
		gap_max = 3;
	endtask

	// Sender goes quiet until every response is back, then resumes
	task automatic test_drain_pause();
		for (int i = 0; i < 50; i++)
			send_req(make_random_req());
		wait_drained();
		for (int i = 0; i < 50; i++)
			send_req(make_random_req());
	endtask

	// Receiver stall pattern, with an occasional long hold
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (stall_phase == 0) begin
			case ($urandom_range(0, 3))
				0: stall_mask = '0;
				1: stall_mask = 16'($urandom);
				2: stall_mask = 16'($urandom & $urandom);
				default: stall_mask = 16'($urandom | $urandom);
			endcase
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= stall_mask[stall_phase];
		end
		stall_phase = (stall_phase + 1) % 16;
	end

	// Response check against the oldest expectation
	rsp_t want_rsp;
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", 64'(rsp.status), '0);
			end else begin
				want_rsp = pending_rsp.pop_front();
				n_checked++;
				if (rsp.status !== want_rsp.status)
					report_mismatch("status", 64'(rsp.status), 64'(want_rsp.status));
				if (rsp.handle_slot !== want_rsp.handle_slot)
					report_mismatch("handle_slot", 64'(rsp.handle_slot),
						64'(want_rsp.handle_slot));
				if (rsp.handle_generation !== want_rsp.handle_generation)
					report_mismatch("handle_generation", 64'(rsp.handle_generation),
						64'(want_rsp.handle_generation));
				if (rsp.read_data !== want_rsp.read_data)
					report_mismatch("read_data", rsp.read_data, want_rsp.read_data);
				if (rsp.live_count !== want_rsp.live_count)
					report_mismatch("live_count", 64'(rsp.live_count),
						64'(want_rsp.live_count));
			end
		end
	end

	// Watchdog on cycles without any transfer
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("[%0t] timeout: no transfer for %0d cycles, %0d responses outstanding",
			$time, IDLE_LIMIT, pending_rsp.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(500);
		test_backpressure();
		test_store_full();
		test_drain_pause();
		test_random_mix(700);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0)
			report_mismatch("missing responses", 64'(pending_rsp.size()), '0);
		$display("Sent %0d requests, checked %0d responses (%0d mismatches)",
			n_sent, n_checked, n_errors);
		$display("Inserts %0d, store full %0d, rejected handles %0d, reads %0d, clears %0d",
			n_inserted, n_full, n_rejected, n_reads, n_clears);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/gha_pkg.sv
hw/rtl/gha_ctrl.sv
hw/rtl/gha_dp.sv
hw/rtl/generational_handle_allocator_unit.sv
tb/tb_top.sv
